@@ sv/oil_pkg.sv @@
// ----------------------------------------------------------------------------
// oil_pkg: shared types and codes for the ordered id list
// Action and status codes, plus the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package oil_pkg;

  // Width of the id fields on the ports.
  localparam int ID_W = 11;

  // Action codes of a request.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_NO_ANCHOR = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the request and read the anchor entries
    logic init_head;   // write the head entry after reset
    logic init_first;  // write the entry of id 1 after reset
    logic exec;        // evaluate the request and do the first writes
    logic link;        // second write cycle of an insert
  } oil_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ins_ok;      // the request is an insert that will be carried out
  } oil_stat_t;

endpackage

@@ sv/ordered_id_list_insert_remove.sv @@
// ----------------------------------------------------------------------------
// ordered_id_list_insert_remove: ordered id list with insert, remove, query
// Remove, query and a rejected insert run through the accept and evaluate
// states; an insert that is carried out adds a link state because its four link
// writes share one write port per link memory. The result strobe comes in
// the cycle after the last busy state, as busy falls, so a new request can be accepted then.
// After reset an initialization pass writes the head and id 1 entries, with busy high.
// ----------------------------------------------------------------------------
module ordered_id_list_insert_remove #(
  parameter int MAX_IDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [oil_pkg::ID_W-1:0]  in_anchor_id,
  input  logic                      in_place_after,
  output logic                      out_valid,
  output logic [oil_pkg::ID_W-1:0]  out_result_id,
  output logic [1:0]                out_status
);

  oil_pkg::oil_cmd_t  cmd;
  oil_pkg::oil_stat_t stat;

  // Controller.
  oil_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath.
  oil_dpath #(
    .MAX_IDS (MAX_IDS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_anchor_id   (in_anchor_id),
    .in_place_after (in_place_after),
    .out_valid      (out_valid),
    .out_result_id  (out_result_id),
    .out_status     (out_status)
  );

endmodule

@@ sv/oil_ctrl.sv @@
// ----------------------------------------------------------------------------
// oil_ctrl: sequencing controller
// Runs the initialization states after reset and steps each request
// through its read, evaluate and, for a carried-out insert, link steps.
// ----------------------------------------------------------------------------
module oil_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  oil_pkg::oil_stat_t stat,
  output oil_pkg::oil_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_INIT0 = 5'b00001,
    S_INIT1 = 5'b00010,
    S_IDLE  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_LINK  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    busy           = 1'b1;
    unique case (state_r)
      S_INIT0: begin
        cmd.init_head = 1'b1;
        state_nxt     = S_INIT1;
      end
      S_INIT1: begin
        cmd.init_first = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.ins_ok ? S_LINK : S_IDLE;
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/oil_dpath.sv @@
// ----------------------------------------------------------------------------
// oil_dpath: link tables, membership memory and result register
// Holds the successor and predecessor link memories, the membership bits
// and the next id counter, and forms the result of each request.
// ----------------------------------------------------------------------------
module oil_dpath #(
  parameter int MAX_IDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  oil_pkg::oil_cmd_t         cmd,
  output oil_pkg::oil_stat_t        stat,
  input  logic [1:0]                in_action,
  input  logic [oil_pkg::ID_W-1:0]  in_anchor_id,
  input  logic                      in_place_after,
  output logic                      out_valid,
  output logic [oil_pkg::ID_W-1:0]  out_result_id,
  output logic [1:0]                out_status
);

  localparam int DEPTH = MAX_IDS + 1;
  localparam int AW    = $clog2(MAX_IDS + 1);
  localparam int LW    = $clog2(MAX_IDS + 2);
  localparam int CW    = (LW > oil_pkg::ID_W) ? LW : oil_pkg::ID_W;

  // Memories: index 0 is the head sentinel.
  logic [AW-1:0] succ_mem [DEPTH];
  logic [AW-1:0] pred_mem [DEPTH];
  logic          pres_mem [DEPTH];

  logic [1:0]               action_r;
  logic [oil_pkg::ID_W-1:0] anchor_r;
  logic                     after_r;
  logic [AW-1:0]            succ_rd_r;
  logic [AW-1:0]            pred_rd_r;
  logic                     pres_rd_r;
  logic [AW-1:0]            prv_r, prv_nxt;
  logic [AW-1:0]            nxt_r, nxt_nxt;
  logic [LW-1:0]            next_id_r;
  logic                     out_valid_r;
  logic [oil_pkg::ID_W-1:0] result_r, result_nxt;
  logic [1:0]               status_r, status_nxt;

  logic          exhausted;
  logic          present;
  logic          ins_ok;
  logic          rem_ok;
  logic [AW-1:0] anchor_a;
  logic [AW-1:0] nid_a;

  logic          succ_we, pred_we, pres_we;
  logic [AW-1:0] succ_wa, pred_wa, pres_wa;
  logic [AW-1:0] succ_wd, pred_wd;
  logic          pres_wd;

  // Request decode. An id below the next new id has been handed out, so
  // the membership bit of such an entry has been written.
  assign anchor_a  = AW'(anchor_r);
  assign nid_a     = AW'(next_id_r);
  assign exhausted = (next_id_r == LW'(MAX_IDS + 1));
  assign present   = (anchor_r != '0) && (CW'(anchor_r) < CW'(next_id_r)) && pres_rd_r;
  assign ins_ok    = (action_r == oil_pkg::ACT_INSERT) && !exhausted && present;
  assign rem_ok    = (action_r == oil_pkg::ACT_REMOVE) && present;
  assign stat.ins_ok = ins_ok;

  // Neighbors of the new or removed entry.
  always_comb begin
    if ((action_r == oil_pkg::ACT_INSERT) && after_r) begin
      prv_nxt = anchor_a;
      nxt_nxt = succ_rd_r;
    end else if (action_r == oil_pkg::ACT_INSERT) begin
      prv_nxt = pred_rd_r;
      nxt_nxt = anchor_a;
    end else begin
      prv_nxt = pred_rd_r;
      nxt_nxt = succ_rd_r;
    end
  end

  // Result of the request.
  always_comb begin
    result_nxt = '0;
    status_nxt = oil_pkg::ST_OK;
    unique case (action_r)
      oil_pkg::ACT_INSERT: begin
        if (exhausted) begin
          status_nxt = oil_pkg::ST_EXHAUSTED;
        end else if (!present) begin
          status_nxt = oil_pkg::ST_NO_ANCHOR;
        end else begin
          result_nxt = oil_pkg::ID_W'(next_id_r);
        end
      end
      oil_pkg::ACT_REMOVE: begin
        if (present) begin
          result_nxt = anchor_r;
        end else begin
          status_nxt = oil_pkg::ST_ABSENT;
        end
      end
      oil_pkg::ACT_QUERY: begin
        if ((anchor_r == '0) || present) begin
          result_nxt = oil_pkg::ID_W'(succ_rd_r);
        end else begin
          status_nxt = oil_pkg::ST_NO_ANCHOR;
        end
      end
      default: begin
        result_nxt = '0;
      end
    endcase
  end

  // Write port selection for the three memories.
  always_comb begin
    succ_we = 1'b0;
    pred_we = 1'b0;
    pres_we = 1'b0;
    succ_wa = '0;
    pred_wa = '0;
    pres_wa = '0;
    succ_wd = '0;
    pred_wd = '0;
    pres_wd = 1'b0;
    priority if (cmd.init_head) begin
      succ_we = 1'b1;
      pred_we = 1'b1;
      succ_wd = AW'(1);
      pred_wd = AW'(1);
    end else if (cmd.init_first) begin
      succ_we = 1'b1;
      pred_we = 1'b1;
      pres_we = 1'b1;
      succ_wa = AW'(1);
      pred_wa = AW'(1);
      pres_wa = AW'(1);
      pres_wd = 1'b1;
    end else if (cmd.exec && ins_ok) begin
      succ_we = 1'b1;
      pred_we = 1'b1;
      pres_we = 1'b1;
      succ_wa = nid_a;
      pred_wa = nid_a;
      pres_wa = nid_a;
      succ_wd = nxt_nxt;
      pred_wd = prv_nxt;
      pres_wd = 1'b1;
    end else if (cmd.exec && rem_ok) begin
      succ_we = 1'b1;
      pred_we = 1'b1;
      pres_we = 1'b1;
      succ_wa = prv_nxt;
      pred_wa = nxt_nxt;
      pres_wa = anchor_a;
      succ_wd = nxt_nxt;
      pred_wd = prv_nxt;
      pres_wd = 1'b0;
    end else if (cmd.link) begin
      succ_we = 1'b1;
      pred_we = 1'b1;
      succ_wa = prv_r;
      pred_wa = nxt_r;
      succ_wd = nid_a;
      pred_wd = nid_a;
    end
  end

  // Successor memory.
  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[succ_wa] <= succ_wd;
    end
    if (cmd.accept) begin
      succ_rd_r <= succ_mem[AW'(in_anchor_id)];
    end
  end

  // Predecessor memory.
  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pred_wa] <= pred_wd;
    end
    if (cmd.accept) begin
      pred_rd_r <= pred_mem[AW'(in_anchor_id)];
    end
  end

  // Membership memory.
  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_wa] <= pres_wd;
    end
    if (cmd.accept) begin
      pres_rd_r <= pres_mem[AW'(in_anchor_id)];
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      anchor_r <= in_anchor_id;
      after_r  <= in_place_after;
    end
    if (cmd.exec) begin
      prv_r    <= prv_nxt;
      nxt_r    <= nxt_nxt;
      result_r <= result_nxt;
      status_r <= status_nxt;
    end
  end

  // Next id counter and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r   <= LW'(2);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.exec && !ins_ok) || cmd.link;
      if (cmd.link) begin
        next_id_r <= LW'(next_id_r + LW'(1));
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_id = result_r;
  assign out_status    = status_r;

endmodule

@@ sv/oil_checker.sv @@
// ----------------------------------------------------------------------------
// oil_checker: port-level checks for the ordered id list
// Watches the request and result ports and checks request timing and
// result consistency.
// ----------------------------------------------------------------------------
module oil_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                in_action,
  input logic                      out_valid,
  input logic [oil_pkg::ID_W-1:0]  out_result_id,
  input logic [1:0]                out_status
);

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  // A result shows while the block is ready for the next request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a request");

  // Anything other than an insert gives its result right after the evaluate state, with no link state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action != oil_pkg::ACT_INSERT)) |-> ##2 out_valid)
    else $error("missing result for a remove or query request");

  // A rejected request returns id zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != oil_pkg::ST_OK)) |-> (out_result_id == '0))
    else $error("nonzero id on a rejected request");

endmodule

bind ordered_id_list_insert_remove oil_checker u_oil_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_result_id (out_result_id),
  .out_status    (out_status)
);
